/* rtl/core/wwrn_pkg.sv */
package wwrn_pkg;

   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
   localparam bit RECTIFY = 1'b1;

   localparam int NUM_W = 94;
   localparam int QUOT_W = 48;

   localparam logic signed [47:0] ONE_Q44 = 48'sh1000_0000_0000;
   localparam logic [47:0] ONE_Q46 = 48'h4000_0000_0000;
   localparam logic [47:0] TWO_Q46 = 48'h8000_0000_0000;
   localparam logic signed [63:0] LOG2E_Q60 = 64'sh1715_4765_2B82_FE17;
   localparam logic [63:0] LN2_Q50 = 64'h00B1_7217_F7D1_CF79 >> 6;
   localparam logic [127:0] MAG_LIMIT = 128'h1 << 62;
   localparam logic signed [63:0] MAX48_EXT = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN48_EXT = 64'shFFFF_8000_0000_0000;

   typedef enum logic [1:0] {SH_28, SH_32, SH_44, SH_60} shift_type;

   typedef enum logic [2:0] {
      CSR_DECAY,
      CSR_DRIVE_GAIN,
      CSR_NOISE_GAIN,
      CSR_RECURRENT_SLOPE,
      CSR_INPUT_SLOPE,
      CSR_SIGMOID_OFFSET,
      CSR_STEEPNESS,
      CSR_OUTPUT_SCALE
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DECAY,
      ST_NOISE,
      ST_REC,
      ST_INP,
      ST_STEEP,
      ST_LOG,
      ST_TBL,
      ST_INTERP,
      ST_DEN,
      ST_DIV,
      ST_DRIVE,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic      start;
      shift_type shift;
   } mul_ctrl_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] full;
      logic signed [47:0] sat;
   } mul_stat_type;

   typedef logic [EXP_TABLE_DEPTH-1:0][47:0] exp_rom_type;

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v > MAX48_EXT) return 48'sh7FFF_FFFF_FFFF;
      if (v < MIN48_EXT) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   // 2^(i/depth) in Q2.46 from a Taylor series of exp(i*ln2/depth)
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type  rom;
      logic [63:0]  y;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [127:0] prod;
      logic [63:0]  rnd;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         y = (LN2_Q50 * 64'(i)) / EXP_TABLE_DEPTH;
         term = 64'h1 << 50;
         sum = term;
         for (int k = 1; k <= 40; k++) begin
            prod = ({64'd0, term} * {64'd0, y}) + (128'h1 << 49);
            term = prod[113:50] / 64'(k);
            sum = sum + term;
         end
         rnd = (sum + 64'd8) >> 4;
         rom[i] = rnd[47:0];
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

/* rtl/core/wwrn_mul.sv */
module wwrn_mul import wwrn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mul_ctrl_type       ctrl,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   output mul_stat_type       stat
);

   logic [63:0]  a_mag_ff, a_mag_in;
   logic [63:0]  b_mag_ff, b_mag_in;
   logic         neg_ff, neg_in;
   shift_type    shift_ff, shift_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_pos;
   logic [127:0] rnd_sum;
   logic [127:0] rounded;
   logic [63:0]  mag_c;
   logic signed [63:0] full;

   assign a_half = cnt_ff[1] ? a_mag_ff[63:32] : a_mag_ff[31:0];
   assign b_half = cnt_ff[0] ? b_mag_ff[63:32] : b_mag_ff[31:0];
   assign pp = {32'd0, a_half} * {32'd0, b_half};

   always_comb begin
      case (cnt_ff)
         2'd0: pp_pos = {64'd0, pp};
         2'd3: pp_pos = {pp, 64'd0};
         default: pp_pos = {32'd0, pp, 32'd0};
      endcase
   end

   // round half away from zero on the magnitude, then shift down
   always_comb begin
      case (shift_ff)
         SH_28: begin
            rnd_sum = acc_ff + (128'h1 << 27);
            rounded = rnd_sum >> 28;
         end
         SH_32: begin
            rnd_sum = acc_ff + (128'h1 << 31);
            rounded = rnd_sum >> 32;
         end
         SH_44: begin
            rnd_sum = acc_ff + (128'h1 << 43);
            rounded = rnd_sum >> 44;
         end
         default: begin
            rnd_sum = acc_ff + (128'h1 << 59);
            rounded = rnd_sum >> 60;
         end
      endcase
   end

   assign mag_c = (rounded > MAG_LIMIT) ? MAG_LIMIT[63:0] : rounded[63:0];
   assign full = neg_ff ? -$signed(mag_c) : $signed(mag_c);

   assign stat.done = done_ff;
   assign stat.full = full;
   assign stat.sat = sat48(full);

   always_comb begin
      a_mag_in = a_mag_ff;
      b_mag_in = b_mag_ff;
      neg_in = neg_ff;
      shift_in = shift_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         a_mag_in = op_a[63] ? 64'(-op_a) : 64'(op_a);
         b_mag_in = op_b[63] ? 64'(-op_b) : 64'(op_b);
         neg_in = op_a[63] ^ op_b[63];
         shift_in = ctrl.shift;
         acc_in = '0;
         cnt_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_pos;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_mag_ff <= a_mag_in;
      b_mag_ff <= b_mag_in;
      neg_ff <= neg_in;
      shift_ff <= shift_in;
      acc_ff <= acc_in;
   end

endmodule

/* rtl/core/wwrn_div.sv */
module wwrn_div import wwrn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [47:0]       den,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   logic [47:0]       rem_ff, rem_in;
   logic [47:0]       low_ff, low_in;
   logic [47:0]       den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [48:0] trial;
   logic        fits;
   logic [48:0] diff;

   assign trial = {rem_ff, low_ff[47]};
   assign fits = trial >= {1'b0, den_ff};
   assign diff = trial - {1'b0, den_ff};

   assign done = done_ff;
   assign quot = quot_ff;

   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      den_in = den_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // quotient fits in 48 bits, so the top part is already below den
         rem_in = {2'b00, num[NUM_W-1:48]};
         low_in = num[47:0];
         den_in = den;
         quot_in = '0;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[47:0] : trial[47:0];
         low_in = {low_ff[46:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
      quot_ff <= quot_in;
   end

endmodule

/* rtl/core/wong_wang_rate_neuron_step.sv */
// A new item is accepted only once the previous result is in the response register.
// Eight products are computed in turn on the shared 32x32 multiplier (issue, four
// partial products, writeback); the sigmoid quotient comes from the divider, which
// yields one bit per cycle. req_ready is high only while the sequencer is idle.
// Synchronous reset clears gating to zero, decay to 1.0, other CSRs to zero.
module wong_wang_rate_neuron_step import wwrn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_normal_sample,
   input  logic signed [47:0] req_coupling_current,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_emitted_current,
   output logic signed [47:0] rsp_new_gating,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data
);

   logic signed [47:0] decay_ff, drive_gain_ff, noise_gain_ff, recurrent_slope_ff;
   logic signed [47:0] input_slope_ff, sigmoid_offset_ff, steepness_ff, output_scale_ff;

   seq_state_type state_ff, state_in;
   logic          wait_ff, wait_in;
   logic signed [47:0] gating_ff, gating_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] z_ff, z_in;
   logic signed [47:0] c_ff, c_in;
   logic signed [47:0] emit_ff, emit_in;
   logic signed [47:0] tmp_ff, tmp_in;
   logic signed [47:0] s1_ff, s1_in;
   logic signed [47:0] x_ff, x_in;
   logic signed [48:0] u_ff, u_in;
   logic signed [63:0] t_ff, t_in;
   logic [47:0]        base_ff, base_in;
   logic [47:0]        next_ff, next_in;
   logic [15:0]        w_ff, w_in;
   logic [47:0]        m_ff, m_in;
   logic signed [47:0] f_ff, f_in;
   logic signed [47:0] s2_ff, s2_in;
   logic signed [47:0] rsp_emit_ff, rsp_emit_in;
   logic signed [47:0] rsp_gating_ff, rsp_gating_in;

   mul_ctrl_type       mul_ctrl;
   mul_stat_type       mul_stat;
   logic signed [63:0] op_a, op_b;
   logic               mul_state;
   logic               mul_fire;

   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   logic [47:0]       div_den;
   logic              div_done;
   logic [QUOT_W-1:0] div_quot;

   logic [EXP_IDX_W-1:0] tbl_idx, tbl_idx_next;
   logic [47:0]          interp_diff;
   logic [63:0]          interp_prod;
   logic signed [31:0]   n_val, k_val;
   logic                 n_wrap;
   logic [47:0]          ax;
   logic [NUM_W-1:0]     num_full;
   logic signed [47:0]   s2_sum;

   wwrn_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctrl  (mul_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .stat  (mul_stat)
   );

   wwrn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_emitted_current = rsp_emit_ff;
   assign rsp_new_gating = rsp_gating_ff;

   assign mul_fire = wait_ff && mul_stat.done;

   assign tbl_idx = t_ff[31 -: EXP_IDX_W];
   assign tbl_idx_next = tbl_idx + 1'b1;
   assign interp_diff = next_ff - base_ff;
   assign interp_prod = {16'd0, interp_diff} * {48'd0, w_ff};

   assign n_val = t_ff[63:32];
   assign k_val = -n_val;
   // integer part is taken from t + 2^50 in 64-bit unsigned arithmetic; below -2^50
   // the sum wraps and lands far above 127, so the quotient is zero
   assign n_wrap = t_ff[63] && !(&t_ff[63:50]);
   assign ax = x_ff[47] ? 48'(-x_ff) : 48'(x_ff);
   assign num_full = {ax, 46'd0};
   assign s2_sum = sat48(64'(s1_ff) + 64'(mul_stat.sat));

   // numerator and denominator of the sigmoid quotient
   always_comb begin
      if (n_wrap) begin
         div_num = '0;
         div_den = m_ff;
      end else if (!n_val[31]) begin
         if (n_val > 32'sd127) begin
            div_num = '0;
         end else begin
            div_num = num_full >> n_val[6:0];
         end
         if (n_val < 32'sd47) begin
            div_den = m_ff + (ONE_Q46 >> n_val[5:0]);
         end else begin
            div_den = m_ff;
         end
      end else begin
         div_num = num_full;
         if (k_val < 32'sd64) begin
            div_den = ONE_Q46 + (m_ff >> k_val[5:0]);
         end else begin
            div_den = ONE_Q46;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      gating_in = gating_ff;
      z_in = z_ff;
      c_in = c_ff;
      emit_in = emit_ff;
      tmp_in = tmp_ff;
      s1_in = s1_ff;
      x_in = x_ff;
      u_in = u_ff;
      t_in = t_ff;
      base_in = base_ff;
      next_in = next_ff;
      w_in = w_ff;
      m_in = m_ff;
      f_in = f_ff;
      s2_in = s2_ff;
      rsp_emit_in = rsp_emit_ff;
      rsp_gating_in = rsp_gating_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_state = 1'b0;
      mul_ctrl.shift = SH_28;
      op_a = '0;
      op_b = '0;
      div_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               z_in = req_normal_sample;
               c_in = req_coupling_current;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_44;
            op_a = 64'(output_scale_ff);
            op_b = 64'(gating_ff);
            if (mul_fire) begin
               emit_in = mul_stat.sat;
               state_in = ST_DECAY;
            end
         end
         ST_DECAY: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_44;
            op_a = 64'(decay_ff);
            op_b = 64'(gating_ff);
            if (mul_fire) begin
               tmp_in = mul_stat.sat;
               state_in = ST_NOISE;
            end
         end
         ST_NOISE: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_28;
            op_a = 64'(noise_gain_ff);
            op_b = 64'(z_ff);
            if (mul_fire) begin
               s1_in = sat48(64'(tmp_ff) + 64'(mul_stat.sat));
               state_in = ST_REC;
            end
         end
         ST_REC: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_44;
            op_a = 64'(recurrent_slope_ff);
            op_b = 64'(s1_ff);
            if (mul_fire) begin
               tmp_in = mul_stat.sat;
               state_in = ST_INP;
            end
         end
         ST_INP: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_32;
            op_a = 64'(input_slope_ff);
            op_b = 64'(c_ff);
            if (mul_fire) begin
               x_in = sat48(64'(tmp_ff) + 64'(mul_stat.sat) + 64'(sigmoid_offset_ff));
               state_in = ST_STEEP;
            end
         end
         ST_STEEP: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_32;
            op_a = 64'(steepness_ff);
            op_b = 64'(x_ff);
            if (mul_fire) begin
               u_in = -(49'(mul_stat.sat));
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_60;
            op_a = 64'(u_ff);
            op_b = LOG2E_Q60;
            if (mul_fire) begin
               t_in = mul_stat.full;
               state_in = ST_TBL;
            end
         end
         ST_TBL: begin
            base_in = EXP_ROM[tbl_idx];
            next_in = (tbl_idx == EXP_IDX_W'(EXP_TABLE_DEPTH - 1)) ?
                      TWO_Q46 : EXP_ROM[tbl_idx_next];
            w_in = t_ff[31-EXP_IDX_W -: 16];
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            m_in = base_ff + interp_prod[63:16];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               f_in = x_ff[47] ? $signed(48'(-div_quot)) : $signed(div_quot);
               state_in = ST_DRIVE;
            end
         end
         ST_DRIVE: begin
            mul_state = 1'b1;
            mul_ctrl.shift = SH_32;
            op_a = 64'(drive_gain_ff);
            op_b = 64'(f_ff);
            if (mul_fire) begin
               s2_in = s2_sum;
               if (RECTIFY) begin
                  if (s2_sum < 48'sd0) begin
                     s2_in = '0;
                  end else if (s2_sum > ONE_Q44) begin
                     s2_in = ONE_Q44;
                  end
               end
               gating_in = s2_in;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_emit_in = emit_ff;
               rsp_gating_in = s2_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mul_ctrl.start = mul_state && !wait_ff;
      wait_in = mul_state && !mul_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff <= 1'b0;
         gating_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         gating_ff <= gating_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
      c_ff <= c_in;
      emit_ff <= emit_in;
      tmp_ff <= tmp_in;
      s1_ff <= s1_in;
      x_ff <= x_in;
      u_ff <= u_in;
      t_ff <= t_in;
      base_ff <= base_in;
      next_ff <= next_in;
      w_ff <= w_in;
      m_ff <= m_in;
      f_ff <= f_in;
      s2_ff <= s2_in;
      rsp_emit_ff <= rsp_emit_in;
      rsp_gating_ff <= rsp_gating_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= ONE_Q44;
         drive_gain_ff <= '0;
         noise_gain_ff <= '0;
         recurrent_slope_ff <= '0;
         input_slope_ff <= '0;
         sigmoid_offset_ff <= '0;
         steepness_ff <= '0;
         output_scale_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DECAY:           decay_ff <= csr_data;
            CSR_DRIVE_GAIN:      drive_gain_ff <= csr_data;
            CSR_NOISE_GAIN:      noise_gain_ff <= csr_data;
            CSR_RECURRENT_SLOPE: recurrent_slope_ff <= csr_data;
            CSR_INPUT_SLOPE:     input_slope_ff <= csr_data;
            CSR_SIGMOID_OFFSET:  sigmoid_offset_ff <= csr_data;
            CSR_STEEPNESS:       steepness_ff <= csr_data;
            CSR_OUTPUT_SCALE:    output_scale_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

/* rtl/core/wwrn_checker.sv */
module wwrn_checker import wwrn_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_new_gating
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the item was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_new_gating))
      else $error("rsp payload changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in progress");

   a_gating_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && RECTIFY |-> rsp_new_gating >= 48'sd0 && rsp_new_gating <= ONE_Q44)
      else $error("gating outside the rectified range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind wong_wang_rate_neuron_step wwrn_checker u_wwrn_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import wwrn_pkg::*;

   typedef struct {
      logic signed [31:0] sample;
      logic signed [47:0] current;
   } step_item_type;

   typedef struct {
      logic signed [47:0] emitted;
      logic signed [47:0] gating;
   } step_result_type;

   localparam logic [63:0] LN2_FRAC50 = 64'h00B1_7217_F7D1_CF79 >> 6;
   localparam logic [63:0] MAG_CAP = 64'h1 << 62;
   localparam logic [63:0] UNIT_Q46 = 64'h1 << 46;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_normal_sample = '0;
   logic signed [47:0] req_coupling_current = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [47:0] rsp_emitted_current;
   logic signed [47:0] rsp_new_gating;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [47:0] csr_data = '0;

   step_item_type   step_queue[$];
   step_result_type expected_steps[$];
   int unsigned     error_count = 0;
   bit              steady = 1'b0;

   // predictor copy of registers, gating and exponent table
   logic signed [47:0] decay_r, drive_r, noise_r, rec_r, inp_r, offset_r, steep_r, scale_r;
   logic signed [47:0] gating_r;
   logic [63:0]        exp_samples[EXP_TABLE_DEPTH];

   wong_wang_rate_neuron_step dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                             input int sh);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) + (128'h1 << (sh - 1));
      prod = prod >> sh;
      if (prod > {64'd0, MAG_CAP}) return MAG_CAP;
      return prod[63:0];
   endfunction

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b, input int sh);
      logic signed [63:0] m;
      m = mul_round(magnitude(a), magnitude(b), sh);
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic logic signed [63:0] clip48(input logic signed [63:0] v);
      if (v > 64'sh0000_7FFF_FFFF_FFFF) return 64'sh0000_7FFF_FFFF_FFFF;
      if (v < -64'sh0000_8000_0000_0000) return -64'sh0000_8000_0000_0000;
      return v;
   endfunction

   function automatic void fill_exp_samples();
      logic [63:0] y, term, sum;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         y = LN2_FRAC50 * 64'(i) / EXP_TABLE_DEPTH;
         term = 64'h1 << 50;
         sum = term;
         for (int k = 1; k <= 40; k++) begin
            term = mul_round(term, y, 50) / 64'(k);
            sum += term;
         end
         exp_samples[i] = (sum + 64'd8) >> 4;
      end
   endfunction

   // x / (1 + 2^(t)), t = -steepness*x*log2(e)
   function automatic logic signed [63:0] sigmoid_quotient(input logic signed [63:0] x);
      logic signed [63:0] u, t, n;
      logic [63:0]        frac, pos, idx, w, base, nxt, m, ax, hi, lo, den, k;
      logic [127:0]       q;
      u = -clip48(fx_mul(steep_r, x, 32));
      t = fx_mul(u, LOG2E_Q60, 60);
      n = signed'((t + (64'h1 << 50)) >> 32) - (64'sh1 << 18);
      frac = {32'd0, t[31:0]};
      pos = frac * EXP_TABLE_DEPTH;
      idx = pos >> 32;
      w = {32'd0, pos[31:0]} >> 16;
      if (idx >= EXP_TABLE_DEPTH) idx = EXP_TABLE_DEPTH - 1;
      base = exp_samples[idx];
      nxt = (idx + 1 < EXP_TABLE_DEPTH) ? exp_samples[idx + 1] : 2 * UNIT_Q46;
      m = base + (((nxt - base) * w) >> 16);
      ax = magnitude(x);
      hi = ax >> 18;
      lo = ax << 46;
      if (n >= 0) begin
         if (n >= 128) return 0;
         if (n >= 64) begin
            lo = hi >> (n - 64);
            hi = 0;
         end else if (n > 0) begin
            lo = (lo >> n) | (hi << (64 - n));
            hi = hi >> n;
         end
         den = m + (n < 47 ? (UNIT_Q46 >> n) : 64'd0);
      end else begin
         k = -n;
         den = UNIT_Q46 + (k < 64 ? (m >> k) : 64'd0);
      end
      q = (den == 0) ? 128'd0 : {hi, lo} / {64'd0, den};
      return x < 0 ? -signed'(q[63:0]) : signed'(q[63:0]);
   endfunction

   function automatic step_result_type advance_neuron(input step_item_type it);
      step_result_type r;
      logic signed [63:0] s, x, f;
      r.emitted = 48'(clip48(fx_mul(scale_r, gating_r, 44)));
      s = clip48(clip48(fx_mul(decay_r, gating_r, 44)) + clip48(fx_mul(noise_r, it.sample, 28)));
      x = clip48(clip48(fx_mul(rec_r, s, 44)) + clip48(fx_mul(inp_r, it.current, 32))
                 + offset_r);
      f = sigmoid_quotient(x);
      s = clip48(s + clip48(fx_mul(drive_r, f, 32)));
      if (RECTIFY) begin
         if (s < 0) s = 0;
         else if (s > ONE_Q44) s = ONE_Q44;
      end
      gating_r = 48'(s);
      r.gating = 48'(s);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         decay_r <= ONE_Q44;
         {drive_r, noise_r, rec_r, inp_r, offset_r, steep_r, scale_r} <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DECAY:           decay_r <= csr_data;
            CSR_DRIVE_GAIN:      drive_r <= csr_data;
            CSR_NOISE_GAIN:      noise_r <= csr_data;
            CSR_RECURRENT_SLOPE: rec_r <= csr_data;
            CSR_INPUT_SLOPE:     inp_r <= csr_data;
            CSR_SIGMOID_OFFSET:  offset_r <= csr_data;
            CSR_STEEPNESS:       steep_r <= csr_data;
            CSR_OUTPUT_SCALE:    scale_r <= csr_data;
            default: ;
         endcase
      end
   end

   // driver: predict on acceptance, then present the next item or idle
   always @(posedge clock) begin
      step_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         gating_r = '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            it.sample = req_normal_sample;
            it.current = req_coupling_current;
            expected_steps.push_back(advance_neuron(it));
         end
         if (step_queue.size() > 0 && (steady || $urandom_range(99) >= 14)) begin
            it = step_queue.pop_front();
            req_normal_sample <= it.sample;
            req_coupling_current <= it.current;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      step_result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               $display("%0t: result with none expected: emitted %h gating %h", $realtime,
                        rsp_emitted_current, rsp_new_gating);
               error_count++;
            end else begin
               e = expected_steps.pop_front();
               if (rsp_emitted_current !== e.emitted) begin
                  $display("%0t: emitted_current expected %h actual %h", $realtime,
                           e.emitted, rsp_emitted_current);
                  error_count++;
               end
               if (rsp_new_gating !== e.gating) begin
                  $display("%0t: new_gating expected %h actual %h", $realtime,
                           e.gating, rsp_new_gating);
                  error_count++;
               end
            end
         end
         rsp_ready <= steady || $urandom_range(99) >= 14;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [47:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (step_queue.size() > 0 || req_valid || expected_steps.size() > 0)
         @(posedge clock);
   endtask

   task automatic queue_step(input logic signed [31:0] z, input logic signed [47:0] c);
      step_item_type it;
      it.sample = z;
      it.current = c;
      step_queue.push_back(it);
   endtask

   function automatic logic [47:0] rand48();
      return {$urandom(), $urandom()};
   endfunction

   // mostly moderate signed values, sometimes extremes or full range
   function automatic logic [47:0] pick(input int bits, input bit nonneg);
      logic [47:0] v;
      case ($urandom_range(9))
         0: return rand48();
         1: return 48'h7FFF_FFFF_FFFF;
         2: return 48'h8000_0000_0000;
         default: begin
            v = rand48() & ((48'h1 << bits) - 1);
            return (!nonneg && $urandom_range(1)) ? -v : v;
         end
      endcase
   endfunction

   task automatic set_all(input logic [47:0] v);
      for (int i = 0; i < 8; i++) write_csr(csr_index_type'(i), v);
   endtask

   initial begin
      fill_exp_samples();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: gating stays zero
      queue_step(32'sh7FFF_FFFF, 48'sh7FFF_FFFF_FFFF);
      queue_step(-32'sh8000_0000, -48'sh8000_0000_0000);
      queue_step(0, 0);
      drain();

      set_all(48'h7FFF_FFFF_FFFF);
      queue_step(32'sh7FFF_FFFF, 48'sh7FFF_FFFF_FFFF);
      queue_step(-32'sh8000_0000, 48'sh7FFF_FFFF_FFFF);
      queue_step(0, -48'sh8000_0000_0000);
      queue_step(32'sh1000_0000, 0);
      drain();

      set_all(48'h8000_0000_0000);
      queue_step(32'sh7FFF_FFFF, -48'sh8000_0000_0000);
      queue_step(-32'sh8000_0000, 48'sh7FFF_FFFF_FFFF);
      queue_step(0, 0);
      drain();

      // plausible neuron: decay 0.9, tiny noise, steep sigmoid of both signs
      write_csr(CSR_DECAY, 48'h0E66_6666_6666);
      write_csr(CSR_DRIVE_GAIN, 48'h0010_0000_0000);
      write_csr(CSR_NOISE_GAIN, 48'h0001_0000_0000);
      write_csr(CSR_RECURRENT_SLOPE, 48'h0001_0000_0000);
      write_csr(CSR_INPUT_SLOPE, 48'h0000_8000_0000);
      write_csr(CSR_SIGMOID_OFFSET, -48'sh0000_4000_0000);
      write_csr(CSR_STEEPNESS, 48'h0040_0000_0000);
      write_csr(CSR_OUTPUT_SCALE, 48'h0001_0000_0000);
      for (int i = 0; i < 6; i++) queue_step($urandom(), pick(36, 0));
      queue_step(0, -48'sh0100_0000_0000);
      queue_step(0, 48'sh0100_0000_0000);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         steady = (phase == 2);
         write_csr(CSR_DECAY, pick(44, 1));
         write_csr(CSR_DRIVE_GAIN, pick(41, 0));
         write_csr(CSR_NOISE_GAIN, pick(38, 0));
         write_csr(CSR_RECURRENT_SLOPE, pick(36, 0));
         write_csr(CSR_INPUT_SLOPE, pick(34, 0));
         write_csr(CSR_SIGMOID_OFFSET, pick(36, 0));
         write_csr(CSR_STEEPNESS, pick(36, 0));
         write_csr(CSR_OUTPUT_SCALE, pick(40, 0));
         for (int i = 0; i < 250; i++) begin
            if ($urandom_range(9) == 0)
               queue_step($urandom(), rand48());
            else
               queue_step($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000,
                          pick(36, 0));
         end
         drain();
      end
      steady = 1'b0;

      repeat (120) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/wwrn_pkg.sv
rtl/core/wwrn_mul.sv
rtl/core/wwrn_div.sv
rtl/core/wong_wang_rate_neuron_step.sv
rtl/core/wwrn_checker.sv
dv/tb_top.sv
